// File: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared types and constants for the button press classifier modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

   localparam int unsigned CsrDataW  = 24;
   localparam int unsigned SlotCount = 5;
   localparam int unsigned SlotCntW  = 3;
   localparam int unsigned FifoDepth = 8;
   localparam int unsigned FifoPtrW  = 3;
   localparam int unsigned FifoCntW  = 4;

   typedef enum logic [2:0] {
      REG_PRESS_MODE    = 3'd0,
      REG_INVERT_MASK   = 3'd1,
      REG_THREE_BUTTONS = 3'd2,
      REG_MIN_PRESS     = 3'd3,
      REG_LONG_PRESS    = 3'd4,
      REG_GAP_MAIN      = 3'd5,
      REG_GAP_THIRD     = 3'd6
   } csr_index_type;

   localparam logic [1:0] MODE_SHORT = 2'd1;
   localparam logic [1:0] MODE_FULL  = 2'd2;

   localparam logic [1:0] ID_PAIR    = 2'd3;
   localparam logic [7:0] CODE_LONG  = 8'd0;
   localparam logic [7:0] CODE_SHORT = 8'd1;

   typedef struct packed {
      logic [1:0]  press_mode;
      logic [2:0]  invert_mask;
      logic        three_buttons;
      logic [19:0] min_press_ticks;
      logic [23:0] long_press_ticks;
      logic [23:0] gap_ticks_main;
      logic [23:0] gap_ticks_third;
   } cfg_type;

   typedef struct packed {
      logic [1:0] button_id;
      logic [7:0] press_code;
   } event_type;

   typedef struct packed {
      logic [SlotCount-1:0]            valid;
      event_type [SlotCount-1:0]       slot;
   } event_bundle_type;

   typedef struct packed {
      logic      last_event;
      event_type ev;
   } entry_type;

endpackage

// File: hw/rtl/bpc_csr.sv
// ----------------------------------------------------------------------------
// Button press classifier register file
// Holds the configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module bpc_csr import bpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_PRESS_MODE:    cfg_in.press_mode       = csr_wdata[1:0];
            REG_INVERT_MASK:   cfg_in.invert_mask      = csr_wdata[2:0];
            REG_THREE_BUTTONS: cfg_in.three_buttons    = csr_wdata[0];
            REG_MIN_PRESS:     cfg_in.min_press_ticks  = csr_wdata[19:0];
            REG_LONG_PRESS:    cfg_in.long_press_ticks = csr_wdata[23:0];
            REG_GAP_MAIN:      cfg_in.gap_ticks_main   = csr_wdata[23:0];
            REG_GAP_THIRD:     cfg_in.gap_ticks_third  = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_mode       <= MODE_FULL;
         cfg_ff.invert_mask      <= 3'd0;
         cfg_ff.three_buttons    <= 1'b0;
         cfg_ff.min_press_ticks  <= 20'd3000;
         cfg_ff.long_press_ticks <= 24'd200000;
         cfg_ff.gap_ticks_main   <= 24'd120000;
         cfg_ff.gap_ticks_third  <= 24'd40000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/bpc_core.sv
// ----------------------------------------------------------------------------
// Button press classifier core
// Tracks levels, press times, click counts and the gap timer, and forms the
// events caused by one sampled tick.
// ----------------------------------------------------------------------------
module bpc_core import bpc_pkg::*; #(
   parameter int unsigned NUM_BUTTONS = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             beat_valid,
   input  logic [2:0]       raw,
   input  cfg_type          cfg,
   output event_bundle_type bundle
);

   localparam logic HasThird = (NUM_BUTTONS >= 3);

   logic [31:0] now_ff, now_in;
   logic [2:0]  prev_ff;
   logic        both_ff, both_in;
   logic [23:0] gap_rem_ff, gap_rem_in;
   logic        gap_run_ff, gap_run_in;

   logic [31:0] start_cur [3];
   logic [31:0] start_in  [3];
   logic [7:0]  count_cur [3];
   logic [7:0]  count_in  [3];

   logic [2:0]  lv, chg;
   logic [23:0] gap_dec;
   logic        expire;
   logic        third;
   logic        edge_hit;
   logic [1:0]  sel_b;
   logic [31:0] dur;
   logic [23:0] gap_load;
   logic        is_short, is_long;
   event_bundle_type bundle_c;

   genvar gb;
   generate
      for (gb = 0; gb < 3; gb++) begin : g_btn
         if (gb < NUM_BUTTONS) begin : g_on
            logic [31:0] start_ff;
            logic [7:0]  count_ff;
            always_ff @(posedge clock) begin
               if (reset) begin
                  start_ff <= 32'd0;
                  count_ff <= 8'd0;
               end else if (beat_valid) begin
                  start_ff <= start_in[gb];
                  count_ff <= count_in[gb];
               end
            end
            assign start_cur[gb] = start_ff;
            assign count_cur[gb] = count_ff;
         end else begin : g_off
            assign start_cur[gb] = 32'd0;
            assign count_cur[gb] = 8'd0;
         end
      end
   endgenerate

   always_comb begin
      lv      = raw ^ cfg.invert_mask;
      chg     = lv ^ prev_ff;
      third   = cfg.three_buttons && HasThird;
      gap_dec = gap_rem_ff - 24'd1;
      expire  = gap_run_ff && (gap_dec == 24'd0);

      gap_rem_in = gap_run_ff ? gap_dec : gap_rem_ff;
      gap_run_in = gap_run_ff && !expire;
      both_in    = both_ff;
      now_in     = now_ff + 32'd1;

      bundle_c = '0;
      for (int b = 0; b < 3; b++) begin
         start_in[b] = start_cur[b];
         count_in[b] = expire ? 8'd0 : count_cur[b];
         bundle_c.valid[b]          = expire && (count_cur[b] != 8'd0);
         bundle_c.slot[b].button_id = 2'(b);
         bundle_c.slot[b].press_code = count_cur[b];
      end

      priority if (chg[0]) begin
         edge_hit = 1'b1;
         sel_b    = 2'd0;
      end else if (chg[1]) begin
         edge_hit = 1'b1;
         sel_b    = 2'd1;
      end else if (chg[2] && third) begin
         edge_hit = 1'b1;
         sel_b    = 2'd2;
      end else begin
         edge_hit = 1'b0;
         sel_b    = 2'd0;
      end

      dur      = now_ff - start_cur[sel_b];
      gap_load = (sel_b == 2'd2) ? cfg.gap_ticks_third : cfg.gap_ticks_main;
      is_short = (sel_b != 2'd2) && (dur < {12'd0, cfg.min_press_ticks});
      is_long  = !is_short && (dur > {8'd0, cfg.long_press_ticks});

      unique case (cfg.press_mode)
         MODE_SHORT: begin
            if (chg[0] && !lv[0]) begin
               bundle_c.valid[3] = 1'b1;
               bundle_c.slot[3]  = '{button_id: 2'd0, press_code: CODE_SHORT};
               start_in[0]       = 32'd0;
            end
            if (chg[1] && !lv[1]) begin
               bundle_c.valid[4] = 1'b1;
               bundle_c.slot[4]  = '{button_id: 2'd1, press_code: CODE_SHORT};
               start_in[1]       = 32'd0;
            end
         end
         MODE_FULL: begin
            priority if (both_ff) begin
               if (lv[0] && lv[1]) begin
                  both_in = 1'b0;
               end
            end else if (!lv[0] && !lv[1]) begin
               bundle_c.valid[3] = 1'b1;
               bundle_c.slot[3]  = '{button_id: ID_PAIR, press_code: CODE_LONG};
               both_in           = 1'b1;
            end else if (edge_hit) begin
               if (lv[sel_b]) begin
                  priority if (is_short) begin
                     count_in[sel_b] = 8'd0;
                  end else if (is_long) begin
                     gap_run_in        = 1'b0;
                     gap_rem_in        = 24'd0;
                     count_in[sel_b]   = 8'd0;
                     bundle_c.valid[3] = 1'b1;
                     bundle_c.slot[3]  = '{button_id: sel_b, press_code: CODE_LONG};
                  end else begin
                     if (count_in[sel_b] != 8'hFF) begin
                        count_in[sel_b] = count_in[sel_b] + 8'd1;
                     end
                     gap_rem_in = (gap_load == 24'd0) ? 24'd1 : gap_load;
                     gap_run_in = 1'b1;
                  end
               end else begin
                  start_in[sel_b] = now_ff;
               end
            end else begin
               both_in = both_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= 32'd0;
         prev_ff    <= 3'b111;
         both_ff    <= 1'b0;
         gap_rem_ff <= 24'd0;
         gap_run_ff <= 1'b0;
      end else if (beat_valid) begin
         now_ff     <= now_in;
         prev_ff    <= lv;
         both_ff    <= both_in;
         gap_rem_ff <= gap_rem_in;
         gap_run_ff <= gap_run_in;
      end
   end

   always_comb begin
      bundle       = bundle_c;
      bundle.valid = beat_valid ? bundle_c.valid : '0;
   end

   // The timer holds a nonzero count exactly while it runs.
   a_gap_running: assert property (@(posedge clock) disable iff (reset)
      gap_run_ff == (gap_rem_ff != 24'd0))
      else $error("gap timer count disagrees with its running flag");

   a_pair_mode: assert property (@(posedge clock) disable iff (reset)
      $rose(both_ff) |-> $past(cfg.press_mode) == MODE_FULL)
      else $error("pair hold set outside full classification");

   a_mode_short_no_pair: assert property (@(posedge clock) disable iff (reset)
      (cfg.press_mode == MODE_SHORT) |-> !(bundle.valid[3] &&
         bundle.slot[3].button_id == ID_PAIR))
      else $error("pair event in short press mode");

endmodule

// File: hw/rtl/bpc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// Button press classifier result queue
// Packs up to five events of one tick into a small queue and hands them out
// one beat at a time.
// ----------------------------------------------------------------------------
module bpc_rsp_fifo import bpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  event_bundle_type bundle,
   output logic             space_ok,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output entry_type        rsp_entry
);

   entry_type             mem_ff [FifoDepth];
   logic [FifoPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntW-1:0]   count_ff, count_in;
   logic [FifoPtrW-1:0]   wr_idx  [SlotCount];
   logic [SlotCount-1:0]  is_last;
   logic [SlotCntW-1:0]   push_n;
   logic                  seen;
   logic                  pop;

   always_comb begin
      push_n = '0;
      for (int k = 0; k < SlotCount; k++) begin
         wr_idx[k] = wr_ptr_ff + FifoPtrW'(push_n);
         if (bundle.valid[k]) begin
            push_n = push_n + SlotCntW'(1);
         end
      end
      seen = 1'b0;
      for (int k = SlotCount - 1; k >= 0; k--) begin
         is_last[k] = bundle.valid[k] && !seen;
         seen       = seen || bundle.valid[k];
      end
   end

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_entry  = mem_ff[rd_ptr_ff];
   assign space_ok   = (count_ff <= FifoCntW'(FifoDepth - SlotCount));

   assign wr_ptr_in = wr_ptr_ff + FifoPtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + FifoPtrW'(pop);
   assign count_in  = count_ff + FifoCntW'(push_n) - FifoCntW'(pop);

   always_ff @(posedge clock) begin
      for (int k = 0; k < SlotCount; k++) begin
         if (bundle.valid[k]) begin
            mem_ff[wr_idx[k]] <= '{last_event: is_last[k], ev: bundle.slot[k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (bundle.valid != '0) |-> space_ok)
      else $error("events pushed without room in the queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FifoCntW'(FifoDepth))
      else $error("queue fill beyond its depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      FifoPtrW'(wr_ptr_ff - rd_ptr_ff) == FifoPtrW'(count_ff))
      else $error("queue pointers disagree with the fill count");

endmodule

// File: hw/rtl/button_press_classifier_unit.sv
// ----------------------------------------------------------------------------
// Button press classifier
// Turns sampled button levels into short, long, multi-click and pair events.
// ----------------------------------------------------------------------------
// Each req beat is one tick carrying the raw levels of three buttons. The
// tick is classified in the cycle it is accepted and its events, zero to
// five of them, are written into an eight-entry result queue at that edge.
// The events of a tick are offered on rsp from the queue registers, after
// any earlier events; rsp_tlast marks the final event caused by that tick,
// and a tick that causes no event produces no rsp beat.
// One tick is accepted every cycle while the queue holds three entries or
// fewer, so that the worst case of five events always fits; the rsp side
// drains one event per cycle. When the receiver stalls, the queue fills and
// req_tready drops until room returns, with nothing lost.
// Reset empties the queue, clears the tick counter, press times, click
// counts and gap timer, treats all buttons as released and loads the
// register defaults. Registers are written through csr_we, csr_index and
// csr_wdata; the user must do this only while no tick is in flight (unenforced).
// ----------------------------------------------------------------------------
module button_press_classifier_unit import bpc_pkg::*; #(
   parameter int unsigned NUM_BUTTONS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // raw_button0, raw_button1, raw_button2
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // button_id[1:0], press_code[9:2]
   output logic                rsp_tlast,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   cfg_type          cfg;
   event_bundle_type bundle;
   entry_type        rsp_entry;
   logic             space_ok;

   assign req_tready = space_ok;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_core #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_tvalid && req_tready),
      .raw        (req_tdata[2:0]),
      .cfg        (cfg),
      .bundle     (bundle)
   );

   bpc_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .space_ok   (space_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_entry  (rsp_entry)
   );

   assign rsp_tdata = {6'd0, rsp_entry.ev.press_code, rsp_entry.ev.button_id};
   assign rsp_tlast = rsp_entry.last_event;

endmodule
